// ----- rtl/sorted_priority_queue_defines.svh -----
// Assertion helpers shared by the queue RTL.
// Each use expects clk and rst in scope.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Check a property once reset has been released.
`define SPQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
package spq_pkg;

  // Default queue depth
  localparam int QUEUE_DEPTH_DEF = 16;

  // Field widths
  localparam int VALUE_W  = 32;
  localparam int RANK_W   = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // One stored entry
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [RANK_W-1:0]  rank;
  } entry_t;

  // Signed rank order: a is served no later than b
  function automatic logic rank_le(input logic signed [RANK_W-1:0] a,
                                   input logic signed [RANK_W-1:0] b);
    return a <= b;
  endfunction

endpackage

// ----- rtl/spq_req_if.sv -----
interface spq_req_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [spq_pkg::VALUE_W-1:0]  item_value;
  logic signed [spq_pkg::RANK_W-1:0]   item_rank;

  modport source (output valid, op, item_value, item_rank, input ready);
  modport sink   (input valid, op, item_value, item_rank, output ready);
endinterface

// ----- rtl/spq_rsp_if.sv -----
interface spq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [spq_pkg::STATUS_W-1:0]        status;
  logic signed [spq_pkg::VALUE_W-1:0]  out_value;
  logic signed [spq_pkg::RANK_W-1:0]   out_rank;
  logic [spq_pkg::OCC_W-1:0]           occupancy;

  modport source (output valid, status, out_value, out_rank, occupancy, input ready);
  modport sink   (input valid, status, out_value, out_rank, occupancy, output ready);
endinterface

// ----- rtl/spq_mem.sv -----
module spq_mem #(
  parameter int DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  spq_pkg::entry_t          wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output spq_pkg::entry_t          rd_data
);
  import spq_pkg::*;

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
// Bounded min-priority queue. Entries sit in rank order in one dual-port
// memory used as a ring: a head pointer marks the smallest rank, so a
// dequeue takes no shifting. An enqueue walks back from the tail, moving
// each entry of larger rank up one slot, one entry per cycle through the
// memory's single write port.
// Equal ranks keep arrival order. A full enqueue (overflow) or an empty
// dequeue (underflow) leaves the queue unchanged.
// One item is in work at a time; a new item is taken while the previous
// result still waits at the output.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PLACE,
    S_DEQ,
    S_DELIVER
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos;
  entry_t           new_entry;
  entry_t           res_entry;
  status_t          res_status;

  logic             acc;
  logic             full_enq;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  entry_t           in_entry;

  // Map a logical slot behind the head to its memory address
  function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign acc            = req.valid && req.ready;
  assign full_enq       = acc && (req.op == OP_ENQ) && (count == DEPTH_C);
  assign req.ready      = (state == S_IDLE);
  assign in_entry.value = req.item_value;
  assign in_entry.rank  = req.item_rank;

  spq_mem #(
    .DEPTH(QUEUE_DEPTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Drive memory reads and writes from the current step
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = head;
    wr_data = new_entry;
    rd_en   = 1'b0;
    rd_addr = head;
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (req.op == OP_ENQ) begin
            if (count == '0) begin
              wr_en   = 1'b1;
              wr_data = in_entry;
            end else if (count != DEPTH_C) begin
              rd_en   = 1'b1;
              rd_addr = wrap(head, count - CNT_W'(1));
            end
          end else if (count != '0) begin
            rd_en = 1'b1;
          end
        end
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = wrap(head, pos);
        if (!rank_le(rd_data.rank, new_entry.rank)) begin
          // Move the larger entry up one slot, fetch the next one down
          wr_data = rd_data;
          if (pos != CNT_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = wrap(head, pos - CNT_W'(2));
          end
        end
      end
      S_PLACE: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // Drop a taken result unless a new one loads in this cycle
      if (rsp.valid && rsp.ready && state != S_DELIVER) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            new_entry  <= in_entry;
            res_entry  <= '0;
            res_status <= ST_OK;
            if (req.op == OP_ENQ) begin
              if (count == DEPTH_C) begin
                res_status <= ST_OVERFLOW;
                state      <= S_DELIVER;
              end else if (count == '0) begin
                count <= count + CNT_W'(1);
                state <= S_DELIVER;
              end else begin
                pos   <= count;
                state <= S_INS;
              end
            end else if (count == '0) begin
              res_status <= ST_UNDERFLOW;
              state      <= S_DELIVER;
            end else begin
              state <= S_DEQ;
            end
          end
        end
        S_INS: begin
          if (rank_le(rd_data.rank, new_entry.rank)) begin
            count <= count + CNT_W'(1);
            state <= S_DELIVER;
          end else begin
            pos <= pos - CNT_W'(1);
            if (pos == CNT_W'(1)) begin
              state <= S_PLACE;
            end
          end
        end
        S_PLACE: begin
          count <= count + CNT_W'(1);
          state <= S_DELIVER;
        end
        S_DEQ: begin
          // Drop the head entry
          res_entry <= rd_data;
          head      <= wrap(head, CNT_W'(1));
          count     <= count - CNT_W'(1);
          state     <= S_DELIVER;
        end
        S_DELIVER: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid     <= 1'b1;
            rsp.status    <= res_status;
            rsp.out_value <= res_entry.value;
            rsp.out_rank  <= res_entry.rank;
            rsp.occupancy <= OCC_W'(count);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SPQ_ASSERT(a_count_bound, count <= DEPTH_C, "entry count beyond queue depth")
  `SPQ_ASSERT(a_pos_range, (state == S_INS) |-> (pos != '0 && pos <= count), "bad insert slot")
  `SPQ_ASSERT(a_full_drop, full_enq |=> ($stable(count) && $stable(head)), "overflow changed queue")
  `SPQ_ASSERT(a_idle_quiet, (state == S_IDLE && !acc) |-> (!wr_en && !rd_en), "idle memory access")

endmodule
